// ===== sv/decimal_display_formatter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Decimal display formatter assertion macros
// Shared property wrappers clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DISPLAY_FORMATTER_TOP_MACROS_SVH
`define DECIMAL_DISPLAY_FORMATTER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DDF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ddf_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal display formatter package
// Shared widths, character codes, digit types and the converter status bundle.
// ----------------------------------------------------------------------------
package ddf_pkg;

    // fixed field widths
    localparam int MAG_WIDTH  = 32;
    localparam int CHAR_WIDTH = 7;
    // decimal digits needed for any 32-bit value
    localparam int BCD_DIGITS = 10;

    typedef logic [3:0]            bcd_digit_t;
    typedef logic [CHAR_WIDTH-1:0] char_t;

    localparam bcd_digit_t DIGIT_NINE = 4'd9;
    localparam char_t      CH_ZERO    = 7'd48;
    localparam char_t      CH_NINE    = 7'd57;
    localparam char_t      CH_POINT   = 7'd46;

    // converter status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

    // ascii code of one decimal digit
    function automatic char_t digit_char(input bcd_digit_t d);
        return CH_ZERO + {3'b000, d};
    endfunction

endpackage

// ===== sv/ddf_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// Decimal display formatter BCD cell
// One decimal digit of the shift-and-add-3 converter chain.
// ----------------------------------------------------------------------------
module ddf_bcd_cell
    import ddf_pkg::*;
(
    input  logic       aclk,
    input  logic       clear,
    input  logic       shift_en,
    input  logic       shift_in,
    output logic       shift_out,
    output bcd_digit_t digit
);

    bcd_digit_t digit_reg;
    bcd_digit_t digit_next;
    bcd_digit_t adj;

    // add 3 when the digit would pass 9 after doubling
    always_comb begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    // clear on a new number, otherwise double and take the neighbor bit
    always_comb begin
        if (clear) begin
            digit_next = '0;
        end else if (shift_en) begin
            digit_next = {adj[2:0], shift_in};
        end else begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign shift_out = adj[3];
    assign digit     = digit_reg;

endmodule

// ===== sv/ddf_bin2bcd.sv =====
// ----------------------------------------------------------------------------
// Decimal display formatter binary to BCD converter
// Shifts the operand one bit per cycle into a row of BCD cells.
// ----------------------------------------------------------------------------
module ddf_bin2bcd
    import ddf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MAG_WIDTH-1:0] operand,
    output conv_status_t         status,
    output bcd_digit_t           digits [BCD_DIGITS]
);

    localparam int CNT_W = $clog2(MAG_WIDTH);

    logic [MAG_WIDTH-1:0] shift_reg;
    logic [MAG_WIDTH-1:0] shift_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic                 carry [BCD_DIGITS+1];

    // bit counter and operand shifter
    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = operand;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[MAG_WIDTH-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
    end

    // row of digit cells, units digit takes the operand msb
    assign carry[0] = shift_reg[MAG_WIDTH-1];

    for (genvar gi = 0; gi < BCD_DIGITS; gi++) begin : g_cell
        ddf_bcd_cell u_cell (
            .aclk      (aclk),
            .clear     (start),
            .shift_en  (busy_reg),
            .shift_in  (carry[gi]),
            .shift_out (carry[gi+1]),
            .digit     (digits[gi])
        );
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== sv/ddf_emitter.sv =====
// ----------------------------------------------------------------------------
// Decimal display formatter character sequencer
// Picks integer and fraction digits, saturates, blanks leading zeros and
// sends one ascii character per transfer through an output register.
// ----------------------------------------------------------------------------
module ddf_emitter
    import ddf_pkg::*;
#(
    parameter int INT_DIGITS  = 5,
    parameter int FRAC_DIGITS = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic         fixed_in,
    input  conv_status_t status,
    input  bcd_digit_t   digits [BCD_DIGITS],
    output logic         ready,
    output logic         out_valid,
    input  logic         out_ready,
    output char_t        out_char,
    output logic         out_last,
    output logic         out_ovf
);

    localparam int INT_LEFT_W  = $clog2(INT_DIGITS + 1);
    localparam int FRAC_LEFT_W = $clog2(FRAC_DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_INT,
        S_POINT,
        S_FRAC
    } state_t;

    state_t                 state_reg, state_next;
    logic                   fixed_reg, fixed_next;
    logic                   ovf_reg, ovf_next;
    logic                   leading_reg, leading_next;
    logic [INT_LEFT_W-1:0]  int_left_reg, int_left_next;
    logic [FRAC_LEFT_W-1:0] frac_left_reg, frac_left_next;
    bcd_digit_t             int_dig_reg [INT_DIGITS];
    bcd_digit_t             int_dig_next [INT_DIGITS];
    bcd_digit_t             frac_dig_reg [FRAC_DIGITS];
    bcd_digit_t             frac_dig_next [FRAC_DIGITS];
    logic                   out_valid_reg, out_valid_next;
    char_t                  out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_ovf_reg, out_ovf_next;

    bcd_digit_t cap_int [INT_DIGITS];
    bcd_digit_t cap_frac [FRAC_DIGITS];
    logic       cap_ovf;
    logic       out_free;

    // integer digits, most significant first, chosen by print mode
    for (genvar gi = 0; gi < INT_DIGITS; gi++) begin : g_int_sel
        localparam int K = INT_DIGITS - 1 - gi;
        bcd_digit_t int_src;
        bcd_digit_t fix_src;
        if (K < BCD_DIGITS) begin : g_int_in
            assign int_src = digits[K];
        end else begin : g_int_out
            assign int_src = '0;
        end
        if (K + FRAC_DIGITS < BCD_DIGITS) begin : g_fix_in
            assign fix_src = digits[K + FRAC_DIGITS];
        end else begin : g_fix_out
            assign fix_src = '0;
        end
        assign cap_int[gi] = cap_ovf   ? DIGIT_NINE :
                             fixed_reg ? fix_src    : int_src;
    end

    // fraction digits, most significant first
    for (genvar gi = 0; gi < FRAC_DIGITS; gi++) begin : g_frac_sel
        assign cap_frac[gi] = digits[FRAC_DIGITS - 1 - gi];
    end

    // any nonzero digit above the integer field means saturation
    always_comb begin
        logic ovf_int;
        logic ovf_fix;
        ovf_int = 1'b0;
        ovf_fix = 1'b0;
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (j >= INT_DIGITS && digits[j] != '0) begin
                ovf_int = 1'b1;
            end
            if (j >= INT_DIGITS + FRAC_DIGITS && digits[j] != '0) begin
                ovf_fix = 1'b1;
            end
        end
        cap_ovf = fixed_reg ? ovf_fix : ovf_int;
    end

    assign out_free = !out_valid_reg || out_ready;

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        fixed_next     = fixed_reg;
        ovf_next       = ovf_reg;
        leading_next   = leading_reg;
        int_left_next  = int_left_reg;
        frac_left_next = frac_left_reg;
        int_dig_next   = int_dig_reg;
        frac_dig_next  = frac_dig_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    fixed_next = fixed_in;
                    state_next = S_CONV;
                end
            end
            S_CONV: begin
                if (status.done) begin
                    int_dig_next  = cap_int;
                    frac_dig_next = cap_frac;
                    ovf_next      = cap_ovf;
                    leading_next  = 1'b1;
                    int_left_next = INT_LEFT_W'(INT_DIGITS);
                    state_next    = S_INT;
                end
            end
            S_INT: begin
                if (out_free) begin
                    // blank a leading zero unless it is the units digit
                    if (!(leading_reg && int_dig_reg[0] == '0 &&
                          int_left_reg != INT_LEFT_W'(1))) begin
                        out_valid_next = 1'b1;
                        out_char_next  = digit_char(int_dig_reg[0]);
                        out_last_next  = !fixed_reg && int_left_reg == INT_LEFT_W'(1);
                        out_ovf_next   = ovf_reg;
                        leading_next   = 1'b0;
                    end
                    for (int i = 0; i < INT_DIGITS - 1; i++) begin
                        int_dig_next[i] = int_dig_reg[i+1];
                    end
                    int_dig_next[INT_DIGITS-1] = '0;
                    int_left_next = int_left_reg - 1'b1;
                    if (int_left_reg == INT_LEFT_W'(1)) begin
                        state_next = fixed_reg ? S_POINT : S_IDLE;
                    end
                end
            end
            S_POINT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_POINT;
                    out_last_next  = 1'b0;
                    out_ovf_next   = ovf_reg;
                    frac_left_next = FRAC_LEFT_W'(FRAC_DIGITS);
                    state_next     = S_FRAC;
                end
            end
            S_FRAC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(frac_dig_reg[0]);
                    out_last_next  = frac_left_reg == FRAC_LEFT_W'(1);
                    out_ovf_next   = ovf_reg;
                    for (int i = 0; i < FRAC_DIGITS - 1; i++) begin
                        frac_dig_next[i] = frac_dig_reg[i+1];
                    end
                    frac_dig_next[FRAC_DIGITS-1] = '0;
                    frac_left_next = frac_left_reg - 1'b1;
                    if (frac_left_reg == FRAC_LEFT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        fixed_reg     <= fixed_next;
        ovf_reg       <= ovf_next;
        leading_reg   <= leading_next;
        int_left_reg  <= int_left_next;
        frac_left_reg <= frac_left_next;
        int_dig_reg   <= int_dig_next;
        frac_dig_reg  <= frac_dig_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign ready     = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

// ===== sv/decimal_display_formatter_top.sv =====
// ----------------------------------------------------------------------------
// Decimal display formatter
// Turns one binary number into its decimal ascii text, one character per
// output transfer.
// ----------------------------------------------------------------------------
// One number is taken at a time. After the input transfer the 32-bit value is
// shifted bit by bit through a row of ten BCD cells, the digits are captured,
// then the sequencer walks the integer digits one per cycle while the output
// is not stalled, blanked ones included, and in fixed mode adds the point and
// the fraction digits. A new number is taken as soon as the last character
// sits in the output register. In fixed mode the value counts units of the
// last fraction digit (hundredths by default) and a negative value prints as
// zero; an integer part beyond INT_DIGITS digits prints as all nines with the
// overflow flag set on every character of that number.
// ----------------------------------------------------------------------------
module decimal_display_formatter_top
    import ddf_pkg::*;
#(
    parameter int INT_DIGITS  = 5,
    parameter int FRAC_DIGITS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // magnitude[31:0], is_negative[32], zero fill
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // text_char[6:0], zero fill
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // overflow[0]
);

    logic                 start;
    logic                 req_fixed;
    logic [MAG_WIDTH-1:0] operand;
    conv_status_t         conv_status;
    bcd_digit_t           digits [BCD_DIGITS];
    char_t                text_char;
    logic                 overflow;

    // input transfer, negative fixed values print as zero
    assign start     = s_tvalid && s_tready;
    assign req_fixed = s_tuser[0];
    assign operand   = (req_fixed && s_tdata[MAG_WIDTH]) ? '0 : s_tdata[MAG_WIDTH-1:0];

    ddf_bin2bcd u_bin2bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .operand (operand),
        .status  (conv_status),
        .digits  (digits)
    );

    ddf_emitter #(
        .INT_DIGITS  (INT_DIGITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .fixed_in  (req_fixed),
        .status    (conv_status),
        .digits    (digits),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (text_char),
        .out_last  (m_tlast),
        .out_ovf   (overflow)
    );

    assign m_tdata = {1'b0, text_char};
    assign m_tuser = overflow;

endmodule

// ===== sv/ddf_checker.sv =====
// ----------------------------------------------------------------------------
// Decimal display formatter port checker
// Watches the top-level ports for character and sequencing rules.
// ----------------------------------------------------------------------------
`include "decimal_display_formatter_top_macros.svh"

module ddf_checker
    import ddf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    // one number at a time: busy right after an input transfer
    `DDF_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "took a second number while converting")

    // only digits or the point leave the block
    `DDF_ASSERT_SAME(a_char_legal, m_tvalid, m_tdata[7] == 1'b0 && ((m_tdata[6:0] >= CH_ZERO && m_tdata[6:0] <= CH_NINE) || m_tdata[6:0] == CH_POINT), "illegal character code")

    // the point is always followed by fraction digits
    `DDF_ASSERT_SAME(a_point_not_last, m_tvalid && m_tdata[6:0] == CH_POINT, !m_tlast, "point marked as last character")

    // a stalled character holds
    `DDF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled character changed")

endmodule

bind decimal_display_formatter_top ddf_checker u_ddf_checker (.*);
